// File: rtl/core/circle_raster_generator_macros.svh
// Assertion macros shared by the circle raster generator RTL.
// Each macro expects i_clk and i_rst_n in the including module.
`ifndef CIRCLE_RASTER_GENERATOR_MACROS_SVH
`define CIRCLE_RASTER_GENERATOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CRG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must never hold
`define CRG_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// File: rtl/core/crg_pkg.sv
// Shared types and constants of the circle raster generator.
// No dependencies.
package crg_pkg;

    localparam int CFG_W = 13;
    localparam logic [CFG_W-1:0] CANVAS_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] CANVAS_HEIGHT_RST = 13'd480;

    localparam logic REG_CANVAS_WIDTH  = 1'b0;
    localparam logic REG_CANVAS_HEIGHT = 1'b1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam int PT_CNT_W = 3;
    localparam logic [PT_CNT_W-1:0] LAST_PT = 3'd7;

    localparam int PIX_IDX_W = 24;
    localparam int COLOR_W   = 32;

    localparam int QDEPTH = 2;
    localparam int QAW    = 1;

    typedef struct packed {
        logic points;
        logic done;
    } t_crg_ctl;

endpackage

// File: rtl/core/crg_queue.sv
// Short FIFO between the item front end and the point back end.
// Depends on crg_pkg and the assertion macro header.
`include "circle_raster_generator_macros.svh"

module crg_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_ready,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    localparam int CNT_W = $clog2(crg_pkg::QDEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(crg_pkg::QDEPTH);
    localparam logic [crg_pkg::QAW-1:0] LAST_IDX = crg_pkg::QAW'(crg_pkg::QDEPTH - 1);

    logic [W-1:0]              r_mem [crg_pkg::QDEPTH];
    logic [crg_pkg::QAW-1:0]   r_wp, n_wp, r_rp, n_rp;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic                      full;

    assign full    = (r_cnt == FULL_CNT);
    assign o_ready = !full;
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == LAST_IDX) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == LAST_IDX) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    `CRG_ASSERT_NEVER(a_no_push_full, i_push && full, "queue push while full")
    `CRG_ASSERT_NEVER(a_no_pop_empty, i_pop && (r_cnt == '0), "queue pop while empty")

endmodule

// File: rtl/core/crg_front.sv
// Front end: accepts items, runs the midpoint iteration state, queues work.
// Depends on crg_pkg and the assertion macro header.
`include "circle_raster_generator_macros.svh"

module crg_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_opcode,
    input  logic signed [COORD_BITS-1:0] i_center_x,
    input  logic signed [COORD_BITS-1:0] i_center_y,
    input  logic signed [COORD_BITS-1:0] i_radius,
    input  logic [crg_pkg::COLOR_W-1:0]  i_color,
    input  logic                         i_q_ready,
    output logic                         o_push,
    output crg_pkg::t_crg_ctl            o_ctl,
    output logic signed [COORD_BITS-1:0] o_cx,
    output logic signed [COORD_BITS-1:0] o_cy,
    output logic signed [COORD_BITS:0]   o_ox,
    output logic signed [COORD_BITS:0]   o_oy,
    output logic [crg_pkg::COLOR_W-1:0]  o_color
);

    localparam int OW = COORD_BITS + 1;
    localparam int DW = COORD_BITS + 4;

    logic signed [OW-1:0]       r_ox, n_ox, r_oy, n_oy;
    logic signed [DW-1:0]       r_dv, n_dv;
    logic signed [COORD_BITS-1:0] r_cx, n_cx, r_cy, n_cy;
    logic [crg_pkg::COLOR_W-1:0] r_color, n_color;
    logic                        r_busy, n_busy;

    logic                 accept, can_step, d_le0, done_step;
    logic signed [OW-1:0] y1, x1;
    logic signed [DW-1:0] y1e, x1e, step_dv;

    assign accept     = i_in_valid && i_q_ready;
    assign o_in_ready = i_q_ready;
    assign o_push     = accept;
    assign o_cx       = r_cx;
    assign o_cy       = r_cy;
    assign o_ox       = r_ox;
    assign o_oy       = r_oy;
    assign o_color    = r_color;

    assign can_step  = r_busy && (r_ox >= r_oy);
    assign y1        = r_oy + OW'(1);
    assign d_le0     = (r_dv <= 0);
    assign x1        = d_le0 ? r_ox : r_ox - OW'(1);
    assign y1e       = DW'(y1);
    assign x1e       = DW'(x1);
    assign step_dv   = r_dv + (y1e <<< 1) + $signed(DW'(1)) - (d_le0 ? '0 : (x1e <<< 1));
    assign done_step = (x1 < y1);

    always_comb begin
        n_ox    = r_ox;
        n_oy    = r_oy;
        n_dv    = r_dv;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_color = r_color;
        n_busy  = r_busy;
        o_ctl   = '{points: 1'b0, done: 1'b1};
        if (i_opcode == crg_pkg::OP_START) begin
            n_ox    = OW'(i_radius);
            n_oy    = '0;
            n_dv    = $signed(DW'(1)) - DW'(i_radius);
            n_cx    = i_center_x;
            n_cy    = i_center_y;
            n_color = i_color;
            n_busy  = !i_radius[COORD_BITS-1];
            o_ctl   = '{points: 1'b0, done: i_radius[COORD_BITS-1]};
        end else if (can_step) begin
            n_ox   = x1;
            n_oy   = y1;
            n_dv   = step_dv;
            n_busy = !done_step;
            o_ctl  = '{points: 1'b1, done: done_step};
        end else begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox    <= '0;
            r_oy    <= '0;
            r_dv    <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
            r_color <= '0;
            r_busy  <= 1'b0;
        end else if (accept) begin
            r_ox    <= n_ox;
            r_oy    <= n_oy;
            r_dv    <= n_dv;
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_color <= n_color;
            r_busy  <= n_busy;
        end
    end

    `CRG_ASSERT_IMP(a_busy_octant, r_busy, (r_ox >= r_oy) && !r_oy[OW-1],
                    "active circle left the first octant")

endmodule

// File: rtl/core/crg_back.sv
// Back end: walks the eight symmetric points of a queued entry, clips them
// and forms the pixel index. Depends on crg_pkg and the assertion macro header.
`include "circle_raster_generator_macros.svh"

module crg_back #(
    parameter int COORD_BITS = 16,
    parameter int DIM_BITS   = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    output logic                          o_pop,
    input  crg_pkg::t_crg_ctl             i_ctl,
    input  logic signed [COORD_BITS-1:0]  i_cx,
    input  logic signed [COORD_BITS-1:0]  i_cy,
    input  logic signed [COORD_BITS:0]    i_ox,
    input  logic signed [COORD_BITS:0]    i_oy,
    input  logic [crg_pkg::COLOR_W-1:0]   i_color,
    input  logic [DIM_BITS:0]             i_width,
    input  logic [DIM_BITS:0]             i_height,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_write_enable,
    output logic [crg_pkg::PIX_IDX_W-1:0] o_pixel_index,
    output logic [crg_pkg::COLOR_W-1:0]   o_pixel_word,
    output logic                          o_last_of_item,
    output logic                          o_circle_done
);

    localparam int PW     = COORD_BITS + 2;
    localparam int CW     = (PW > DIM_BITS + 2) ? PW : DIM_BITS + 2;
    localparam int PROD_W = (2 * DIM_BITS + 1 > crg_pkg::PIX_IDX_W) ?
                            2 * DIM_BITS + 1 : crg_pkg::PIX_IDX_W;

    logic [crg_pkg::PT_CNT_W-1:0] r_k;
    logic adv_a, adv_b, load_a;

    logic signed [COORD_BITS:0] sel_a, sel_b;
    logic signed [PW-1:0]       ae, be, px, py;
    logic signed [CW-1:0]       pxc, pyc, wc, hc;
    logic                       in_canvas;

    logic                        r_a_valid, r_a_we, r_a_last, r_a_done;
    logic [DIM_BITS-1:0]         r_a_px, r_a_py;
    logic [crg_pkg::COLOR_W-1:0] r_a_color;

    logic [PROD_W-1:0] idx;

    logic                          r_o_valid, r_o_we, r_o_last, r_o_done;
    logic [crg_pkg::PIX_IDX_W-1:0] r_o_idx;
    logic [crg_pkg::COLOR_W-1:0]   r_o_word;

    assign adv_b  = !r_o_valid || i_out_ready;
    assign adv_a  = !r_a_valid || adv_b;
    assign load_a = adv_a && i_q_valid;
    assign o_pop  = load_a && (r_k == crg_pkg::LAST_PT);

    // points 4..7 swap the roles of x and y; bit 0 mirrors column, bit 1 row
    assign sel_a = r_k[2] ? i_oy : i_ox;
    assign sel_b = r_k[2] ? i_ox : i_oy;
    assign ae    = PW'(sel_a);
    assign be    = PW'(sel_b);
    assign px    = PW'(i_cx) + (r_k[0] ? -ae : ae);
    assign py    = PW'(i_cy) + (r_k[1] ? -be : be);
    assign pxc   = CW'(px);
    assign pyc   = CW'(py);
    assign wc    = $signed(CW'(i_width));
    assign hc    = $signed(CW'(i_height));
    assign in_canvas = i_ctl.points && !px[PW-1] && !py[PW-1] && (pxc < wc) && (pyc < hc);

    assign idx = PROD_W'(r_a_py) * PROD_W'(i_width) + PROD_W'(r_a_px);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k       <= '0;
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (load_a) begin
                r_k <= r_k + 1'b1;
            end
            if (adv_a) begin
                r_a_valid <= i_q_valid;
            end
            if (adv_b) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_a) begin
            r_a_we    <= in_canvas;
            r_a_last  <= (r_k == crg_pkg::LAST_PT);
            r_a_done  <= i_ctl.done;
            r_a_px    <= pxc[DIM_BITS-1:0];
            r_a_py    <= pyc[DIM_BITS-1:0];
            r_a_color <= i_color;
        end
        if (adv_b && r_a_valid) begin
            r_o_we   <= r_a_we;
            r_o_last <= r_a_last;
            r_o_done <= r_a_done;
            r_o_idx  <= r_a_we ? idx[crg_pkg::PIX_IDX_W-1:0] : '0;
            r_o_word <= r_a_we ? r_a_color : '0;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_write_enable = r_o_we;
    assign o_pixel_index  = r_o_idx;
    assign o_pixel_word   = r_o_word;
    assign o_last_of_item = r_o_last;
    assign o_circle_done  = r_o_done;

    `CRG_ASSERT_IMP(a_clip_zero, r_o_valid && !r_o_we, (r_o_idx == '0) && (r_o_word == '0),
                    "clipped beat carries nonzero payload")
    `CRG_ASSERT_IMP(a_px_in_row, r_a_valid && r_a_we, ({1'b0, r_a_px} < i_width),
                    "written point beyond canvas width")

endmodule

// File: rtl/core/circle_raster_generator.sv
// Midpoint circle outline generator: every item yields eight result beats.
// Throughput: one beat per cycle from the point pipeline while the receiver is ready.
// A 2-entry queue lets the front accept while earlier items are drawn.
// Reset (sync, active low) clears the circle state and queue, canvas 640x480.
module circle_raster_generator #(
    parameter int COORD_BITS = 16,
    parameter int DIM_BITS   = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_opcode,
    input  logic signed [COORD_BITS-1:0]  i_center_x,
    input  logic signed [COORD_BITS-1:0]  i_center_y,
    input  logic signed [COORD_BITS-1:0]  i_radius,
    input  logic [7:0]                    i_red,
    input  logic [7:0]                    i_green,
    input  logic [7:0]                    i_blue,
    input  logic [7:0]                    i_alpha,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_write_enable,
    output logic [crg_pkg::PIX_IDX_W-1:0] o_pixel_index,
    output logic [crg_pkg::COLOR_W-1:0]   o_pixel_word,
    output logic                          o_last_of_item,
    output logic                          o_circle_done
);

    localparam int CFG_W = crg_pkg::CFG_W;
    localparam int LW    = (CFG_W > DIM_BITS + 1) ? CFG_W : DIM_BITS + 1;
    localparam int QW    = $bits(crg_pkg::t_crg_ctl) + 4 * COORD_BITS + 2 + crg_pkg::COLOR_W;

    logic [CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic             cfg_wr;
    logic [LW-1:0]    w_ext, h_ext, dim_lim, w_cap, h_cap;
    logic [DIM_BITS:0] width, height;

    crg_pkg::t_crg_ctl            f_ctl, b_ctl;
    logic                         push, pop, q_ready, q_valid;
    logic signed [COORD_BITS-1:0] f_cx, f_cy, b_cx, b_cy;
    logic signed [COORD_BITS:0]   f_ox, f_oy, b_ox, b_oy;
    logic [crg_pkg::COLOR_W-1:0]  f_color, b_color;
    logic [QW-1:0]                q_in, q_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == crg_pkg::REG_CANVAS_HEIGHT) ? 32'(r_cfg_h) : 32'(r_cfg_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= crg_pkg::CANVAS_WIDTH_RST;
            r_cfg_h <= crg_pkg::CANVAS_HEIGHT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == crg_pkg::REG_CANVAS_HEIGHT) begin
                r_cfg_h <= pwdata[CFG_W-1:0];
            end else begin
                r_cfg_w <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign w_ext   = LW'(r_cfg_w);
    assign h_ext   = LW'(r_cfg_h);
    assign dim_lim = LW'(1) << DIM_BITS;
    assign w_cap   = (w_ext > dim_lim) ? dim_lim : w_ext;
    assign h_cap   = (h_ext > dim_lim) ? dim_lim : h_ext;
    assign width   = w_cap[DIM_BITS:0];
    assign height  = h_cap[DIM_BITS:0];

    crg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_opcode   (i_opcode),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_color    ({i_alpha, i_blue, i_green, i_red}),
        .i_q_ready  (q_ready),
        .o_push     (push),
        .o_ctl      (f_ctl),
        .o_cx       (f_cx),
        .o_cy       (f_cy),
        .o_ox       (f_ox),
        .o_oy       (f_oy),
        .o_color    (f_color)
    );

    assign q_in = {f_ctl, f_cx, f_cy, f_ox, f_oy, f_color};
    assign {b_ctl, b_cx, b_cy, b_ox, b_oy, b_color} = q_out;

    crg_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    crg_back #(
        .COORD_BITS (COORD_BITS),
        .DIM_BITS   (DIM_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .o_pop          (pop),
        .i_ctl          (b_ctl),
        .i_cx           (b_cx),
        .i_cy           (b_cy),
        .i_ox           (b_ox),
        .i_oy           (b_oy),
        .i_color        (b_color),
        .i_width        (width),
        .i_height       (height),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_write_enable (o_write_enable),
        .o_pixel_index  (o_pixel_index),
        .o_pixel_word   (o_pixel_word),
        .o_last_of_item (o_last_of_item),
        .o_circle_done  (o_circle_done)
    );

endmodule

// File: verif/tb.sv
// Self-checking bench for circle_raster_generator: canvas setup over APB, start and
// step beats with random sender gaps and receiver stalls, every output beat checked.
// Depends on crg_pkg and the circle_raster_generator RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS = 16;
    localparam int DIM_BITS = 12;
    localparam int DIM_CAP = 1 << DIM_BITS;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RX_FREE = 0;
    localparam int RX_COIN = 1;
    localparam int RX_BURSTY = 2;

    typedef struct {
        logic                         op;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] rad;
        logic [7:0]                   red;
        logic [7:0]                   green;
        logic [7:0]                   blue;
        logic [7:0]                   alpha;
    } t_draw_cmd;

    typedef struct {
        logic                          we;
        logic [crg_pkg::PIX_IDX_W-1:0] index;
        logic [crg_pkg::COLOR_W-1:0]   word;
        logic                          last;
        logic                          done;
    } t_pixel;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic i_opcode = 1'b0;
    logic signed [COORD_BITS-1:0] i_center_x = '0;
    logic signed [COORD_BITS-1:0] i_center_y = '0;
    logic signed [COORD_BITS-1:0] i_radius = '0;
    logic [7:0] i_red = '0;
    logic [7:0] i_green = '0;
    logic [7:0] i_blue = '0;
    logic [7:0] i_alpha = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic o_write_enable;
    logic [crg_pkg::PIX_IDX_W-1:0] o_pixel_index;
    logic [crg_pkg::COLOR_W-1:0] o_pixel_word;
    logic o_last_of_item;
    logic o_circle_done;

    circle_raster_generator #(
        .COORD_BITS(COORD_BITS),
        .DIM_BITS  (DIM_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius      (i_radius),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_alpha       (i_alpha),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_write_enable(o_write_enable),
        .o_pixel_index (o_pixel_index),
        .o_pixel_word  (o_pixel_word),
        .o_last_of_item(o_last_of_item),
        .o_circle_done (o_circle_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // predictor state, reset values
    logic [crg_pkg::CFG_W-1:0] canvas_w = crg_pkg::CANVAS_WIDTH_RST;
    logic [crg_pkg::CFG_W-1:0] canvas_h = crg_pkg::CANVAS_HEIGHT_RST;
    longint ofs_x = 0;
    longint ofs_y = 0;
    longint decision = 0;
    longint cen_x = 0;
    longint cen_y = 0;
    logic [crg_pkg::COLOR_W-1:0] color = '0;
    bit drawing = 1'b0;

    t_draw_cmd cmd_q[$];
    t_pixel expected_pixels[$];
    int mismatches = 0;

    function automatic int capped(logic [crg_pkg::CFG_W-1:0] d);
        return (d > DIM_CAP) ? DIM_CAP : int'(d);
    endfunction

    function automatic void emit_point(int k, longint px, longint py, bit done);
        t_pixel p;
        longint w;
        longint h;
        bit on_canvas;
        w = capped(canvas_w);
        h = capped(canvas_h);
        on_canvas = px >= 0 && py >= 0 && px < w && py < h;
        p.we = on_canvas;
        p.index = on_canvas ? crg_pkg::PIX_IDX_W'(py * w + px) : '0;
        p.word = on_canvas ? color : '0;
        p.last = (k == 7);
        p.done = done;
        expected_pixels.push_back(p);
    endfunction

    function automatic void predict_pixels(t_draw_cmd c);
        longint x;
        longint y;
        bit done;
        if (c.op == crg_pkg::OP_START) begin
            cen_x = longint'(c.cx);
            cen_y = longint'(c.cy);
            color = {c.alpha, c.blue, c.green, c.red};
            ofs_x = longint'(c.rad);
            ofs_y = 0;
            decision = 1 - ofs_x;
            drawing = ofs_x >= 0;
            for (int k = 0; k < 8; k++) emit_point(k, -1, -1, !drawing);
        end else if (!drawing || ofs_x < ofs_y) begin
            drawing = 1'b0;
            for (int k = 0; k < 8; k++) emit_point(k, -1, -1, 1'b1);
        end else begin
            x = ofs_x;
            y = ofs_y;
            ofs_y = y + 1;
            if (decision <= 0) begin
                decision += 2 * ofs_y + 1;
            end else begin
                ofs_x = x - 1;
                decision += 2 * ofs_y - 2 * ofs_x + 1;
            end
            done = ofs_x < ofs_y;
            if (done) drawing = 1'b0;
            emit_point(0, cen_x + x, cen_y + y, done);
            emit_point(1, cen_x - x, cen_y + y, done);
            emit_point(2, cen_x + x, cen_y - y, done);
            emit_point(3, cen_x - x, cen_y - y, done);
            emit_point(4, cen_x + y, cen_y + x, done);
            emit_point(5, cen_x - y, cen_y + x, done);
            emit_point(6, cen_x + y, cen_y - x, done);
            emit_point(7, cen_x - y, cen_y - x, done);
        end
    endfunction

    task automatic check_beat(t_pixel e);
        if (o_write_enable !== e.we) begin
            $error("write_enable: expected %0d, got %0d", e.we, o_write_enable);
            mismatches++;
        end
        if (o_pixel_index !== e.index) begin
            $error("pixel_index: expected %0d, got %0d", e.index, o_pixel_index);
            mismatches++;
        end
        if (o_pixel_word !== e.word) begin
            $error("pixel_word: expected %08h, got %08h", e.word, o_pixel_word);
            mismatches++;
        end
        if (o_last_of_item !== e.last) begin
            $error("last_of_item: expected %0d, got %0d", e.last, o_last_of_item);
            mismatches++;
        end
        if (o_circle_done !== e.done) begin
            $error("circle_done: expected %0d, got %0d", e.done, o_circle_done);
            mismatches++;
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_pixels('{i_opcode, i_center_x, i_center_y, i_radius,
                                 i_red, i_green, i_blue, i_alpha});
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("output beat with no expected pixel pending");
                    mismatches++;
                end else begin
                    check_beat(expected_pixels.pop_front());
                end
            end
        end
    end

    // driver: bursts with random gaps
    t_draw_cmd drv_cmd;
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                drv_cmd = cmd_q.pop_front();
                i_opcode <= drv_cmd.op;
                i_center_x <= drv_cmd.cx;
                i_center_y <= drv_cmd.cy;
                i_radius <= drv_cmd.rad;
                i_red <= drv_cmd.red;
                i_green <= drv_cmd.green;
                i_blue <= drv_cmd.blue;
                i_alpha <= drv_cmd.alpha;
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, mode redrawn at random whenever rx_tick wraps
    int rx_mode = RX_FREE;
    int rx_hold = 0;
    logic [5:0] rx_tick = '0;

    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1'b1;
        if (rx_tick == 6'd63) rx_mode <= $urandom_range(RX_FREE, RX_BURSTY);
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_FREE: begin
                    i_out_ready <= 1'b1;
                end
                RX_COIN: begin
                    i_out_ready <= $urandom_range(0, 1);
                end
                default: begin
                    if ($urandom_range(0, 7) == 0) begin
                        rx_hold <= $urandom_range(1, 20);
                        i_out_ready <= 1'b0;
                    end else begin
                        i_out_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    int stuck_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    function automatic t_draw_cmd start_cmd(int cx, int cy, int rad, logic [31:0] rgba);
        t_draw_cmd c;
        c.op = crg_pkg::OP_START;
        c.cx = COORD_BITS'(cx);
        c.cy = COORD_BITS'(cy);
        c.rad = COORD_BITS'(rad);
        {c.alpha, c.blue, c.green, c.red} = rgba;
        return c;
    endfunction

    // payload of a step is ignored, so it carries random bits
    function automatic t_draw_cmd step_cmd();
        t_draw_cmd c;
        c.op = crg_pkg::OP_STEP;
        c.cx = COORD_BITS'($urandom);
        c.cy = COORD_BITS'($urandom);
        c.rad = COORD_BITS'($urandom);
        {c.alpha, c.blue, c.green, c.red} = $urandom;
        return c;
    endfunction

    task automatic push_circle(int cx, int cy, int rad, logic [31:0] rgba, int steps);
        cmd_q.push_back(start_cmd(cx, cy, rad, rgba));
        repeat (steps) cmd_q.push_back(step_cmd());
    endtask

    task automatic random_circles(int n_items);
        int pushed;
        int sel;
        int rad;
        int steps;
        int cx;
        int cy;
        pushed = 0;
        while (pushed < n_items) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                rad = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
                cx = int'($urandom_range(0, capped(canvas_w) + 2 * rad + 4)) - rad - 2;
                cy = int'($urandom_range(0, capped(canvas_h) + 2 * rad + 4)) - rad - 2;
                steps = rad * 3 / 4 + 2 + $urandom_range(0, 1);
                if (sel == 6) steps = $urandom_range(0, steps);
                push_circle(cx, cy, rad, $urandom, steps);
            end else if (sel == 7) begin
                steps = $urandom_range(0, 3);
                push_circle($urandom, $urandom, $urandom, $urandom, steps);
            end else if (sel == 8) begin
                steps = 1;
                push_circle($urandom, $urandom, -int'($urandom_range(1, 32768)), $urandom, steps);
            end else begin
                steps = $urandom_range(0, 2);
                repeat (steps + 1) cmd_q.push_back(step_cmd());
            end
            pushed += steps + 1;
        end
    endtask

    task automatic apb_write(logic reg_idx, logic [crg_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= {19'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_idx == crg_pkg::REG_CANVAS_WIDTH) canvas_w = val;
        else canvas_h = val;
    endtask

    // sender holds off until every expected beat is back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (cmd_q.size() != 0 || i_in_valid || expected_pixels.size() != 0);
        repeat (12) @(posedge i_clk);
    endtask

    initial begin
        int cfg_w[8] = '{1, 4096, 8191, 0, 300, 37, 4097, 0};
        int cfg_h[8] = '{1, 4096, 8191, 300, 0, 23, 4095, 0};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        cmd_q.push_back(step_cmd());
        push_circle(0, 0, 0, 32'hFFFF_FFFF, 2);
        push_circle(32767, -32768, -32768, 32'h0, 1);
        push_circle(-32768, 32767, 32767, $urandom, 2);
        push_circle(320, 240, 5, $urandom, 6);
        push_circle(639, 479, 3, $urandom, 4);
        push_circle(0, 0, 32767, $urandom, 1);

        for (int p = 0; p < 8; p++) begin
            wait_idle();
            if (p == 7) begin
                cfg_w[p] = $urandom_range(1, 4096);
                cfg_h[p] = $urandom_range(1, 4096);
            end
            apb_write(crg_pkg::REG_CANVAS_WIDTH, crg_pkg::CFG_W'(cfg_w[p]));
            apb_write(crg_pkg::REG_CANVAS_HEIGHT, crg_pkg::CFG_W'(cfg_h[p]));
            random_circles(37);
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (expected_pixels.size() != 0) begin
            $error("%0d expected beats never arrived", expected_pixels.size());
        end
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
